FILE: rtl/amc_pkg.sv
// ---------------------------------------------------------------------------
// amc_pkg
// Shared widths, sequencer states and divider interface types for the
// amicable number checker.
// ---------------------------------------------------------------------------
package amc_pkg;

    // Width of the numbers on the input ports.
    localparam int NUM_W   = 24;
    // Operand width of the divider: a partner candidate stays below twice the
    // centre number, so one extra bit covers it.
    localparam int OP_W    = NUM_W + 1;
    // Divisor sums stay below eight times the number.
    localparam int SUM_W   = OP_W + 3;
    // Trial divisors run up to the square root of an operand, plus one.
    localparam int D_W     = (OP_W + 1) / 2;
    localparam int SQ_W    = 2 * D_W;
    // Bounds of the search window need one bit more than an operand.
    localparam int BND_W   = OP_W + 1;
    localparam int CNT_W   = $clog2(OP_W + 1);
    localparam int RAD_W   = 8;
    localparam int RAD_RST = 3;

    // APB register map.
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;
    localparam logic [0:0] REG_RADIUS = 1'b0;

    typedef enum logic [0:0] {
        OP_PAIR   = 1'b0,
        OP_SEARCH = 1'b1
    } t_opcode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RAD,
        ST_RAD_WAIT,
        ST_SUM_TEST,
        ST_SUM_DIV,
        ST_EVAL,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic            start;
        logic [OP_W-1:0] dividend;
        logic [OP_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic            done;
        logic [OP_W-1:0] quotient;
        logic [OP_W-1:0] remainder;
    } t_div_rsp;

endpackage

FILE: rtl/amicable_number_check.sv
// ---------------------------------------------------------------------------
// amicable_number_check
// Answers amicable pair checks and partner searches with one shared divider.
// ---------------------------------------------------------------------------
// A query is taken when start is high and busy is low. Opcode pair check
// asks whether the two numbers are amicable; opcode range search asks
// whether the first number has an amicable partner within plus (exclusive)
// or minus (inclusive) the number divided by the radius divisor register.
// The answer appears on o_is_amicable for exactly one cycle with o_valid
// high; the receiver cannot hold it off, and busy drops the cycle after.
// The one restoring divider serves every trial divisor in turn. A query
// runs up to two divisor sums: one of the first number and, when it
// passes, one of the partner, which for a search may reach 25 bits. A
// range search with a nonzero radius adds one division for it. The radius
// divisor is written over the APB port at byte address 0; the user must
// write it only while the block is idle, which the block itself does not
// enforce. It resets to 3. Reset returns the sequencer to idle.
// ---------------------------------------------------------------------------
module amicable_number_check (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_opcode,
    input  logic [amc_pkg::NUM_W-1:0]  i_first_number,
    input  logic [amc_pkg::NUM_W-1:0]  i_second_number,
    output logic                       o_valid,
    output logic                       o_is_amicable,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [amc_pkg::APB_AW-1:0] paddr,
    input  logic [amc_pkg::APB_DW-1:0] pwdata,
    output logic [amc_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import amc_pkg::*;

    logic [RAD_W-1:0] r_radius;
    t_div_req         div_req;
    t_div_rsp         div_rsp;
    logic             reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == REG_RADIUS);
    assign prdata  = reg_sel ? APB_DW'(r_radius) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RAD_W'(RAD_RST);
        end else if (psel && penable && pwrite && reg_sel) begin
            r_radius <= pwdata[RAD_W-1:0];
        end
    end

    amc_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_opcode        (i_opcode),
        .i_first_number  (i_first_number),
        .i_second_number (i_second_number),
        .i_radius        (r_radius),
        .o_div_req       (div_req),
        .i_div_rsp       (div_rsp),
        .o_valid         (o_valid),
        .o_is_amicable   (o_is_amicable)
    );

    amc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

endmodule

FILE: rtl/amc_div.sv
// ---------------------------------------------------------------------------
// amc_div
// Restoring divider that settles one quotient bit per clock cycle.
// ---------------------------------------------------------------------------
module amc_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  amc_pkg::t_div_req i_req,
    output amc_pkg::t_div_rsp o_rsp
);
    import amc_pkg::*;

    logic [OP_W-1:0]  r_quo, n_quo;
    logic [OP_W:0]    r_rem, n_rem;
    logic [OP_W-1:0]  r_dvs, n_dvs;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_run, n_run;
    logic             r_done, n_done;
    logic [OP_W:0]    shifted;
    logic [OP_W+1:0]  trial;

    always_comb begin
        shifted = {r_rem[OP_W-1:0], r_quo[OP_W-1]};
        trial   = {1'b0, shifted} - {2'b00, r_dvs};
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_dvs   = r_dvs;
        n_cnt   = r_cnt;
        n_run   = r_run;
        n_done  = 1'b0;
        if (i_req.start) begin
            n_quo = i_req.dividend;
            n_rem = '0;
            n_dvs = i_req.divisor;
            n_cnt = CNT_W'(OP_W);
            n_run = 1'b1;
        end else if (r_run) begin
            // A borrow in the top bit means the divisor did not fit.
            if (trial[OP_W+1]) begin
                n_rem = shifted;
                n_quo = {r_quo[OP_W-2:0], 1'b0};
            end else begin
                n_rem = trial[OP_W:0];
                n_quo = {r_quo[OP_W-2:0], 1'b1};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem[OP_W-1:0];

endmodule

FILE: rtl/amc_seq.sv
// ---------------------------------------------------------------------------
// amc_seq
// Sequencer that sets the search window, walks trial divisors up to the
// square root, builds the divisor sums and decides the answer from them.
// ---------------------------------------------------------------------------
module amc_seq (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_opcode,
    input  logic [amc_pkg::NUM_W-1:0] i_first_number,
    input  logic [amc_pkg::NUM_W-1:0] i_second_number,
    input  logic [amc_pkg::RAD_W-1:0] i_radius,
    output amc_pkg::t_div_req         o_div_req,
    input  amc_pkg::t_div_rsp         i_div_rsp,
    output logic                      o_valid,
    output logic                      o_is_amicable
);
    import amc_pkg::*;

    t_state           r_state, n_state;
    logic             r_op, n_op;
    logic [NUM_W-1:0] r_a, n_a;
    logic [NUM_W-1:0] r_b, n_b;
    logic [OP_W-1:0]  r_n, n_n;
    logic [D_W-1:0]   r_d, n_d;
    logic [SQ_W-1:0]  r_sq, n_sq;
    logic [SUM_W-1:0] r_s, n_s;
    logic [BND_W-1:0] r_lo, n_lo;
    logic [BND_W-1:0] r_hi, n_hi;
    logic             r_phase, n_phase;
    logic             r_res, n_res;
    logic             sum_over;
    logic             in_window;
    logic [OP_W-1:0]  d_ext;
    logic [OP_W-1:0]  cofactor;

    // The walk ends once the square of the trial divisor passes the number.
    assign sum_over  = r_sq > {{(SQ_W-OP_W){1'b0}}, r_n};
    assign in_window = (r_s >= SUM_W'(r_lo)) && (r_s < SUM_W'(r_hi))
                       && (r_s != SUM_W'(r_a));
    assign d_ext     = OP_W'(r_d);
    assign cofactor  = (i_div_rsp.quotient != d_ext) ? i_div_rsp.quotient : '0;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (i_opcode == OP_SEARCH) begin
                        n_state = (i_radius == '0) ? ST_DONE : ST_RAD;
                    end else begin
                        n_state = ST_SUM_TEST;
                    end
                end
            end
            ST_RAD:      n_state = ST_RAD_WAIT;
            ST_RAD_WAIT: begin
                if (i_div_rsp.done) begin
                    n_state = ST_SUM_TEST;
                end
            end
            ST_SUM_TEST: n_state = sum_over ? ST_EVAL : ST_SUM_DIV;
            ST_SUM_DIV: begin
                if (i_div_rsp.done) begin
                    n_state = ST_SUM_TEST;
                end
            end
            ST_EVAL: begin
                if (r_phase) begin
                    n_state = ST_DONE;
                end else if (r_op == OP_SEARCH) begin
                    n_state = in_window ? ST_SUM_TEST : ST_DONE;
                end else begin
                    n_state = (r_s == SUM_W'(r_b)) ? ST_SUM_TEST : ST_DONE;
                end
            end
            ST_DONE:     n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // Outputs and divider requests.
    always_comb begin
        o_div_req.start    = 1'b0;
        o_div_req.dividend = r_n;
        o_div_req.divisor  = d_ext;
        unique case (r_state)
            ST_RAD: begin
                o_div_req.start    = 1'b1;
                o_div_req.dividend = OP_W'(r_a);
                o_div_req.divisor  = OP_W'(i_radius);
            end
            ST_SUM_TEST: o_div_req.start = !sum_over;
            default: begin
                o_div_req.start = 1'b0;
            end
        endcase
        busy          = (r_state != ST_IDLE);
        o_valid       = (r_state == ST_DONE);
        o_is_amicable = r_res;
    end

    // Datapath.
    always_comb begin
        n_op    = r_op;
        n_a     = r_a;
        n_b     = r_b;
        n_n     = r_n;
        n_d     = r_d;
        n_sq    = r_sq;
        n_s     = r_s;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_phase = r_phase;
        n_res   = r_res;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_op    = i_opcode;
                    n_a     = i_first_number;
                    n_b     = i_second_number;
                    n_n     = OP_W'(i_first_number);
                    n_d     = D_W'(2);
                    n_sq    = SQ_W'(4);
                    n_s     = SUM_W'(1);
                    n_phase = 1'b0;
                    n_res   = 1'b0;
                end
            end
            ST_RAD_WAIT: begin
                if (i_div_rsp.done) begin
                    n_lo = BND_W'(r_a) - BND_W'(i_div_rsp.quotient);
                    n_hi = BND_W'(r_a) + BND_W'(i_div_rsp.quotient);
                end
            end
            ST_SUM_DIV: begin
                if (i_div_rsp.done) begin
                    if (i_div_rsp.remainder == '0) begin
                        n_s = r_s + SUM_W'(d_ext) + SUM_W'(cofactor);
                    end
                    // (d+1)^2 = d^2 + 2d + 1
                    n_sq = r_sq + SQ_W'({r_d, 1'b1});
                    n_d  = r_d + 1'b1;
                end
            end
            ST_EVAL: begin
                if (r_phase) begin
                    n_res = (r_s == SUM_W'(r_a));
                end else begin
                    // Second sum: of the claimed partner, which must give back a.
                    n_phase = 1'b1;
                    n_n     = (r_op == OP_SEARCH) ? r_s[OP_W-1:0] : OP_W'(r_b);
                    n_d     = D_W'(2);
                    n_sq    = SQ_W'(4);
                    n_s     = SUM_W'(1);
                end
            end
            default: begin
                n_res = r_res;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_res   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_res   <= n_res;
        end
        r_op    <= n_op;
        r_a     <= n_a;
        r_b     <= n_b;
        r_n     <= n_n;
        r_d     <= n_d;
        r_sq    <= n_sq;
        r_s     <= n_s;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_phase <= n_phase;
    end

endmodule

FILE: bench/amicable_number_check_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// amicable_number_check_tb
// Drives pair checks and partner searches into the amicable number checker
// and compares every answer with a divisor-sum predictor held in the bench.
// The radius divisor is rewritten over APB between phases while the block
// is idle, covering the reset value, one, the maximum, zero and a random one.
// ---------------------------------------------------------------------------
module amicable_number_check_tb;

    import amc_pkg::*;

    localparam int IDLE_LIMIT       = 1_000_000;
    localparam int RANDOM_PER_PHASE = 16;
    localparam logic [NUM_W-1:0] NUM_MAX = {NUM_W{1'b1}};

    // Expected answers, in the order the queries were taken.
    class amicable_answers;
        bit          pending_verdicts[$];
        logic [RAD_W-1:0] radius;
        int          mismatches;

        function new();
            radius     = RAD_RST;
            mismatches = 0;
        endfunction

        function void set_radius(logic [RAD_W-1:0] r);
            radius = r;
        endfunction

        // One plus every divisor from 2 up to n/2, walked in pairs to sqrt(n).
        function longint unsigned divisor_sum(longint unsigned n);
            longint unsigned s;
            longint unsigned d;
            if (n < 2) begin
                return 1;
            end
            s = 1;
            for (d = 2; d * d <= n; d++) begin
                if (n % d == 0) begin
                    s += d;
                    if (n / d != d) begin
                        s += n / d;
                    end
                end
            end
            return s;
        endfunction

        function void note_query(t_opcode op, logic [NUM_W-1:0] a, logic [NUM_W-1:0] b);
            longint unsigned rad;
            longint unsigned lo;
            longint unsigned hi;
            longint unsigned s;
            bit              hit;
            hit = 1'b0;
            if (op == OP_PAIR) begin
                hit = (divisor_sum(a) == b) && (divisor_sum(b) == a);
            end else if (radius != 0) begin
                rad = a / radius;
                lo  = a - rad;
                hi  = a + rad;
                s   = divisor_sum(a);
                hit = (s >= lo) && (s < hi) && (s != a) && (divisor_sum(s) == a);
            end
            pending_verdicts.push_back(hit);
        endfunction

        function void check_verdict(logic got);
            bit want;
            if (pending_verdicts.size() == 0) begin
                $error("is_amicable: expected nothing, got %0b", got);
                mismatches++;
            end else begin
                want = pending_verdicts.pop_front();
                if (got !== want) begin
                    $error("is_amicable: expected %0b, got %0b", want, got);
                    mismatches++;
                end
            end
        endfunction

        function int outstanding();
            return pending_verdicts.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic start;
    logic busy;
    logic i_opcode;
    logic [NUM_W-1:0] i_first_number;
    logic [NUM_W-1:0] i_second_number;
    logic o_valid;
    logic o_is_amicable;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic pready;

    amicable_answers answers;
    int  idle_cycles = 0;
    bit  steady;

    int unsigned pair_lo [0:12] = '{220, 1184, 2620, 5020, 6232, 10744, 12285,
                                    17296, 63020, 66928, 67095, 69615, 79750};
    int unsigned pair_hi [0:12] = '{284, 1210, 2924, 5564, 6368, 10856, 14595,
                                    18416, 76084, 66992, 71145, 87633, 88730};
    int unsigned perfect [0:3]  = '{6, 28, 496, 8128};

    amicable_number_check dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_opcode        (i_opcode),
        .i_first_number  (i_first_number),
        .i_second_number (i_second_number),
        .o_valid         (o_valid),
        .o_is_amicable   (o_is_amicable),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Result checking and the watchdog: any beat on either port counts as progress.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            answers.check_verdict(o_is_amicable);
        end
        if (!i_rst_n || o_valid || (start && !busy) || (psel && penable && pready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("amicable_number_check_tb failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 50) begin
            return 0;
        end else if (roll < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 40);
    endfunction

    function automatic logic [NUM_W-1:0] small_number();
        if ($urandom_range(0, 24) == 0) begin
            return '0;
        end
        return NUM_W'($urandom_range(1, 4095));
    endfunction

    // Called at a falling edge; returns at a falling edge after the beat and gap.
    task automatic run_query(input t_opcode op, input logic [NUM_W-1:0] a,
                             input logic [NUM_W-1:0] b);
        int gap;
        start           = 1'b1;
        i_opcode        = op;
        i_first_number  = a;
        i_second_number = b;
        do begin
            @(posedge i_clk);
        end while (busy !== 1'b0);
        answers.note_query(op, a, b);
        @(negedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        start = 1'b0;
        while (answers.outstanding() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_radius(input logic [APB_DW-1:0] word);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = APB_AW'(REG_RADIUS) << 2;
        pwdata  = word;
        @(negedge i_clk);
        penable = 1'b1;
        do begin
            @(posedge i_clk);
        end while (pready !== 1'b1);
        answers.set_radius(word[RAD_W-1:0]);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Mostly well-formed questions: known pairs, near misses, a number paired
    // with its own divisor sum, and searches around known pair members.
    task automatic random_query();
        int               sel;
        int               k;
        t_opcode          op;
        logic [NUM_W-1:0] a;
        logic [NUM_W-1:0] b;
        logic [NUM_W-1:0] t;
        sel = $urandom_range(0, 99);
        k   = $urandom_range(0, 12);
        op  = OP_PAIR;
        a   = NUM_W'(pair_lo[k]);
        b   = NUM_W'(pair_hi[k]);
        if (sel < 30) begin
            if ($urandom_range(0, 1) == 1) begin
                t = a;
                a = b;
                b = t;
            end
        end else if (sel < 42) begin
            b = b ^ NUM_W'(1 << $urandom_range(0, 15));
        end else if (sel < 55) begin
            a = small_number();
            b = NUM_W'(answers.divisor_sum(a));
        end else if (sel < 80) begin
            op = OP_SEARCH;
            case ($urandom_range(0, 4))
                0, 1:    a = NUM_W'(pair_lo[k]);
                2:       a = NUM_W'(pair_hi[k]);
                3:       a = NUM_W'(perfect[$urandom_range(0, 3)]);
                default: a = small_number();
            endcase
            b = NUM_W'($urandom());
        end else if (sel < 95) begin
            a = small_number();
            b = small_number();
        end else begin
            op = t_opcode'($urandom_range(0, 1));
            a  = NUM_W'($urandom_range(0, (1 << 18) - 1));
            b  = NUM_W'($urandom_range(0, (1 << 18) - 1));
        end
        run_query(op, a, b);
    endtask

    task automatic random_phase();
        steady = ($urandom_range(0, 3) == 0);
        repeat (RANDOM_PER_PHASE) random_query();
        steady = 1'b0;
    endtask

    initial begin
        logic [APB_DW-1:0] word;
        answers         = new();
        steady          = 1'b0;
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_opcode        = OP_PAIR;
        i_first_number  = '0;
        i_second_number = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Radius divisor at its reset value.
        run_query(OP_PAIR,   24'd220,   24'd284);
        run_query(OP_PAIR,   24'd284,   24'd220);
        run_query(OP_PAIR,   24'd220,   24'd285);
        run_query(OP_PAIR,   24'd6,     24'd6);
        run_query(OP_PAIR,   24'd0,     24'd0);
        run_query(OP_PAIR,   24'd1,     24'd1);
        run_query(OP_PAIR,   24'd0,     24'd1);
        run_query(OP_PAIR,   24'd1,     NUM_MAX);
        run_query(OP_PAIR,   NUM_MAX,   NUM_MAX);
        run_query(OP_SEARCH, 24'd0,     NUM_MAX);
        run_query(OP_SEARCH, 24'd1,     24'd0);
        run_query(OP_SEARCH, 24'd220,   24'd0);
        run_query(OP_SEARCH, 24'd284,   24'd1);
        run_query(OP_SEARCH, 24'd6,     24'd6);
        run_query(OP_SEARCH, 24'd12285, 24'd0);
        run_query(OP_SEARCH, 24'd1184,  24'd0);
        run_query(OP_SEARCH, NUM_MAX,   NUM_MAX);
        random_phase();

        // Radius divisor one: the window opens down to zero.
        drain();
        write_radius(32'd1);
        run_query(OP_SEARCH, 24'd220, 24'd0);
        run_query(OP_SEARCH, 24'd0,   24'd0);
        run_query(OP_SEARCH, 24'd1,   24'd0);
        random_phase();

        drain();
        write_radius(32'd255);
        run_query(OP_SEARCH, 24'd220,   24'd0);
        run_query(OP_SEARCH, 24'd63020, 24'd0);
        random_phase();

        // Zero radius divisor leaves every search window empty.
        drain();
        write_radius(32'd0);
        run_query(OP_SEARCH, 24'd220, 24'd0);
        random_phase();

        // Upper bits of the write data carry noise; only the low byte counts.
        drain();
        word            = $urandom();
        word[RAD_W-1:0] = RAD_W'($urandom_range(2, 254));
        write_radius(word);
        random_phase();

        start = 1'b0;
        while (answers.outstanding() != 0) begin
            @(negedge i_clk);
        end
        repeat (30) @(posedge i_clk);
        if (answers.outstanding() != 0) begin
            $error("is_amicable: %0d answers never arrived", answers.outstanding());
        end
        if (answers.mismatches == 0 && answers.outstanding() == 0) begin
            $display("amicable_number_check_tb passed");
        end else begin
            $display("amicable_number_check_tb failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/amc_pkg.sv
rtl/amc_div.sv
rtl/amc_seq.sv
rtl/amicable_number_check.sv
bench/amicable_number_check_tb.sv
